[sv/lth_pkg.sv]
package lth_pkg;

  // Configuration register indexes, in the order of the register list.
  typedef enum logic [2:0] {
    REG_ALPHA     = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_HYST      = 3'd2,
    REG_DEBOUNCE  = 3'd3,
    REG_HOLD      = 3'd4,
    REG_RELEASE   = 3'd5
  } cfg_reg_e;

  // Item kinds carried on the input tuser bit.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Field widths.
  localparam int unsigned AlphaW = 9;
  localparam int unsigned LevelW = 16;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CfgW   = 16;

  // Alpha limits, Q1.8.
  localparam logic [AlphaW-1:0] AlphaMin = 9'd3;
  localparam logic [AlphaW-1:0] AlphaMax = 9'd256;

  // Reset values of the configuration registers.
  localparam logic [AlphaW-1:0] AlphaReset     = 9'd256;
  localparam logic [LevelW-1:0] ThresholdReset = 16'd32768;

  // Register file contents seen by the trigger core.
  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic [LevelW-1:0] threshold;
    logic [LevelW-1:0] hyst;
    logic [MsW-1:0]    debounce_ms;
    logic [MsW-1:0]    hold_ms;
    logic [MsW-1:0]    release_ms;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic              active;
    logic              turned_on;
    logic              turned_off;
    logic [LevelW-1:0] smoothed_level;
  } res_t;

endpackage

[sv/lth_cfg_regs.sv]
module lth_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lth_pkg::IdxW-1:0]       cfg_index_i,
  input  logic [lth_pkg::CfgW-1:0]       cfg_data_i,
  output lth_pkg::cfg_t                  cfg_o
);

  lth_pkg::cfg_t cfg_q;

  // Writes are taken in any cycle; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha       <= lth_pkg::AlphaReset;
      cfg_q.threshold   <= lth_pkg::ThresholdReset;
      cfg_q.hyst        <= '0;
      cfg_q.debounce_ms <= '0;
      cfg_q.hold_ms     <= '0;
      cfg_q.release_ms  <= '0;
    end else if (cfg_valid_i) begin
      case (lth_pkg::cfg_reg_e'(cfg_index_i))
        lth_pkg::REG_ALPHA:     cfg_q.alpha       <= cfg_data_i[lth_pkg::AlphaW-1:0];
        lth_pkg::REG_THRESHOLD: cfg_q.threshold   <= cfg_data_i;
        lth_pkg::REG_HYST:      cfg_q.hyst        <= cfg_data_i;
        lth_pkg::REG_DEBOUNCE:  cfg_q.debounce_ms <= cfg_data_i;
        lth_pkg::REG_HOLD:      cfg_q.hold_ms     <= cfg_data_i;
        lth_pkg::REG_RELEASE:   cfg_q.release_ms  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[sv/lth_trigger_core.sv]
module lth_trigger_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         command_i,
  input  logic [lth_pkg::LevelW-1:0]   level_i,
  input  lth_pkg::cfg_t                cfg_i,
  output lth_pkg::res_t                res_o
);

  localparam int unsigned LW = lth_pkg::LevelW;
  localparam int unsigned TW = lth_pkg::TimeW;

  logic [LW-1:0] avg_q, avg_d;
  logic          trig_q, trig_d;
  logic          qual_q, qual_d;
  logic          db_act_q, db_act_d;
  logic          hold_q, hold_d;
  logic          rel_q, rel_d;
  logic [TW-1:0] now_q, now_d;
  logic [TW-1:0] db_start_q, db_start_d;
  logic [TW-1:0] hold_start_q, hold_start_d;
  logic [TW-1:0] rel_start_q, rel_start_d;

  logic [lth_pkg::AlphaW-1:0] alpha;
  logic signed [LW:0]         diff;
  logic signed [LW+10:0]      prod;
  logic signed [LW+11:0]      ema_sum;
  logic [LW-1:0]              ema_avg;

  logic [TW-1:0] tick_now;
  logic [LW-1:0] eff_thr;
  logic          above;
  logic [TW-1:0] db_elapsed;
  logic [TW-1:0] hold_elapsed;
  logic [TW-1:0] rel_elapsed;

  // Moving average as avg + a*(level - avg), so one multiplier does it.
  always_comb begin
    alpha = cfg_i.alpha;
    if (alpha < lth_pkg::AlphaMin) begin
      alpha = lth_pkg::AlphaMin;
    end else if (alpha > lth_pkg::AlphaMax) begin
      alpha = lth_pkg::AlphaMax;
    end
    diff    = $signed({1'b0, level_i}) - $signed({1'b0, avg_q});
    prod    = $signed({1'b0, alpha}) * diff;
    ema_sum = $signed({4'b0, avg_q, 8'b0}) + (LW+12)'(prod) + (LW+12)'(128);
    ema_avg = ema_sum[LW+7:8];
  end

  // A sample updates the average; a tick runs threshold compare, debounce, hold and release.
  always_comb begin
    avg_d        = avg_q;
    trig_d       = trig_q;
    qual_d       = qual_q;
    db_act_d     = db_act_q;
    hold_d       = hold_q;
    rel_d        = rel_q;
    now_d        = now_q;
    db_start_d   = db_start_q;
    hold_start_d = hold_start_q;
    rel_start_d  = rel_start_q;

    tick_now = now_q + TW'(1);
    if (trig_q) begin
      eff_thr = (cfg_i.threshold > cfg_i.hyst) ? cfg_i.threshold - cfg_i.hyst : '0;
    end else begin
      eff_thr = cfg_i.threshold;
    end
    above        = avg_q >= eff_thr;
    db_elapsed   = db_act_q ? tick_now - db_start_q : '0;
    hold_elapsed = tick_now - hold_start_q;
    rel_elapsed  = tick_now - rel_start_q;

    if (command_i == lth_pkg::CMD_SAMPLE) begin
      avg_d = ema_avg;
    end else begin
      now_d = tick_now;

      // Debounce: a changed compare must persist before it qualifies.
      if (above != qual_q) begin
        db_act_d = 1'b1;
        if (!db_act_q) begin
          db_start_d = tick_now;
        end
        if (db_elapsed >= TW'(cfg_i.debounce_ms)) begin
          qual_d   = above;
          db_act_d = 1'b0;
        end
      end else begin
        db_act_d = 1'b0;
      end

      // Trigger with hold then release delay.
      if (!trig_q) begin
        if (qual_d) begin
          trig_d       = 1'b1;
          hold_d       = 1'b1;
          hold_start_d = tick_now;
          rel_d        = 1'b0;
        end
      end else if (!qual_d) begin
        if (hold_q) begin
          if (hold_elapsed >= TW'(cfg_i.hold_ms)) begin
            hold_d      = 1'b0;
            rel_d       = 1'b1;
            rel_start_d = tick_now;
          end
        end else if (rel_q) begin
          if (rel_elapsed >= TW'(cfg_i.release_ms)) begin
            trig_d = 1'b0;
            rel_d  = 1'b0;
          end
        end
      end else begin
        hold_d       = 1'b1;
        hold_start_d = tick_now;
        rel_d        = 1'b0;
      end
    end
  end

  assign res_o.active         = trig_d;
  assign res_o.turned_on      = trig_d & ~trig_q;
  assign res_o.turned_off     = ~trig_d & trig_q;
  assign res_o.smoothed_level = avg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q        <= '0;
      trig_q       <= 1'b0;
      qual_q       <= 1'b0;
      db_act_q     <= 1'b0;
      hold_q       <= 1'b0;
      rel_q        <= 1'b0;
      now_q        <= '0;
      db_start_q   <= '0;
      hold_start_q <= '0;
      rel_start_q  <= '0;
    end else if (en_i) begin
      avg_q        <= avg_d;
      trig_q       <= trig_d;
      qual_q       <= qual_d;
      db_act_q     <= db_act_d;
      hold_q       <= hold_d;
      rel_q        <= rel_d;
      now_q        <= now_d;
      db_start_q   <= db_start_d;
      hold_start_q <= hold_start_d;
      rel_start_q  <= rel_start_d;
    end
  end

endmodule

[sv/level_trigger_hold_release.sv]
// Channel     Direction  Handshake                       Payload
// s_axis      in         s_axis_tvalid / s_axis_tready   tdata level, tuser command
// m_axis      out        m_axis_tvalid / m_axis_tready   tdata active, edges, average
// cfg         in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// One request per cycle is sustained while the output is not stalled: a request is
// registered in the input register, and the trigger core computes its result into
// the output register, from which the result is offered.
// Reset clears the trigger state, timers and average, and loads register defaults.
// When the output stalls, the input register holds one more request, then
// s_axis_tready drops. The config port is always ready.
module level_trigger_hold_release (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,   // [15:0] level
  input  logic [0:0]                     s_axis_tuser,   // [0] command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] active, [1] turned_on, [2] turned_off, [18:3] smoothed_level, [23:19] zero
  output logic [23:0]                    m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lth_pkg::IdxW-1:0]       cfg_index_i,
  input  logic [lth_pkg::CfgW-1:0]       cfg_data_i
);

  logic                        in_valid_q;
  logic                        in_cmd_q;
  logic [lth_pkg::LevelW-1:0]  in_level_q;
  logic                        out_valid_q;
  lth_pkg::res_t               out_res_q;
  lth_pkg::res_t               res;
  lth_pkg::cfg_t               cfg;
  logic                        advance;

  // A request moves to the output when that register is free or being drained.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  lth_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lth_trigger_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .command_i (in_cmd_q),
    .level_i   (in_level_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q   <= s_axis_tuser[0];
      in_level_q <= s_axis_tdata;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.smoothed_level, out_res_q.turned_off,
                          out_res_q.turned_on, out_res_q.active};

endmodule

[sv/lth_checker.sv]
module lth_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [23:0]               m_axis_tdata
);

  // Both edge pulses never appear in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("turned_on and turned_off both set");

  // An edge pulse agrees with the trigger state it reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1] || m_axis_tdata[2]) |->
      (m_axis_tdata[0] == m_axis_tdata[1]))
    else $error("edge pulse disagrees with active");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind level_trigger_hold_release lth_checker u_lth_checker (.*);

[verif/level_trigger_hold_release_test.sv]
`timescale 1ns / 100ps

module level_trigger_hold_release_test;
  import lth_pkg::*;

  localparam int unsigned ClkHalf      = 4;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseItems   = 48;
  // Index that names no register; a write to it must change nothing.
  localparam logic [IdxW-1:0] RegUnused = 3'd7;

  // Predicts the trigger results and holds them until the block returns them.
  class trigger_scoreboard;
    logic [AlphaW-1:0] alpha;
    logic [LevelW-1:0] threshold;
    logic [LevelW-1:0] hyst;
    logic [MsW-1:0]    debounce_ms;
    logic [MsW-1:0]    hold_ms;
    logic [MsW-1:0]    release_ms;

    logic [LevelW-1:0] average;
    bit                triggered;
    bit                qualified;
    bit                debouncing;
    bit                holding;
    bit                releasing;
    logic [TimeW-1:0]  now_ms;
    logic [TimeW-1:0]  debounce_t0;
    logic [TimeW-1:0]  hold_t0;
    logic [TimeW-1:0]  release_t0;

    res_t        expected_q[$];
    int unsigned mismatches;

    function new();
      alpha       = AlphaReset;
      threshold   = ThresholdReset;
      hyst        = '0;
      debounce_ms = '0;
      hold_ms     = '0;
      release_ms  = '0;
      average     = '0;
      triggered   = 1'b0;
      qualified   = 1'b0;
      debouncing  = 1'b0;
      holding     = 1'b0;
      releasing   = 1'b0;
      now_ms      = '0;
      debounce_t0 = '0;
      hold_t0     = '0;
      release_t0  = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_ALPHA:     alpha       = data[AlphaW-1:0];
        REG_THRESHOLD: threshold   = data;
        REG_HYST:      hyst        = data;
        REG_DEBOUNCE:  debounce_ms = data;
        REG_HOLD:      hold_ms     = data;
        REG_RELEASE:   release_ms  = data;
        default: ;
      endcase
    endfunction

    // Moving average with alpha clamped to the supported Q1.8 range.
    function void update_average(logic [LevelW-1:0] level);
      logic [31:0] a;
      logic [31:0] sum;
      a = 32'(alpha);
      if (a < 32'(AlphaMin)) a = 32'(AlphaMin);
      if (a > 32'(AlphaMax)) a = 32'(AlphaMax);
      sum = a * 32'(level) + (32'd256 - a) * 32'(average) + 32'd128;
      average = sum[LevelW+7:8];
    endfunction

    // One millisecond: debounce the comparison, then run hold and release.
    function void advance_ms();
      logic [LevelW-1:0] eff;
      bit                above;
      now_ms = now_ms + 1;
      if (triggered) eff = (threshold > hyst) ? threshold - hyst : '0;
      else eff = threshold;
      above = (average >= eff);

      if (above != qualified) begin
        if (!debouncing) begin
          debouncing  = 1'b1;
          debounce_t0 = now_ms;
        end
        if (now_ms - debounce_t0 >= 32'(debounce_ms)) begin
          qualified  = above;
          debouncing = 1'b0;
        end
      end else begin
        debouncing = 1'b0;
      end

      if (!triggered) begin
        if (qualified) begin
          triggered = 1'b1;
          holding   = 1'b1;
          hold_t0   = now_ms;
          releasing = 1'b0;
        end
      end else if (!qualified) begin
        if (holding) begin
          if (now_ms - hold_t0 >= 32'(hold_ms)) begin
            holding    = 1'b0;
            releasing  = 1'b1;
            release_t0 = now_ms;
          end
        end else if (releasing) begin
          if (now_ms - release_t0 >= 32'(release_ms)) begin
            triggered = 1'b0;
            releasing = 1'b0;
          end
        end
      end else begin
        holding   = 1'b1;
        hold_t0   = now_ms;
        releasing = 1'b0;
      end
    endfunction

    function void note_request(logic cmd, logic [LevelW-1:0] level);
      bit   was_on;
      res_t r;
      was_on = triggered;
      if (cmd == CMD_SAMPLE) update_average(level);
      else advance_ms();
      r.active         = triggered;
      r.turned_on      = triggered && !was_on;
      r.turned_off     = !triggered && was_on;
      r.smoothed_level = average;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [23:0] tdata);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", tdata));
        return;
      end
      exp_r = expected_q.pop_front();
      if (tdata[0] !== exp_r.active)
        report_mismatch($sformatf("active %b, want %b", tdata[0], exp_r.active));
      if (tdata[1] !== exp_r.turned_on)
        report_mismatch($sformatf("turned_on %b, want %b", tdata[1], exp_r.turned_on));
      if (tdata[2] !== exp_r.turned_off)
        report_mismatch($sformatf("turned_off %b, want %b", tdata[2], exp_r.turned_off));
      if (tdata[18:3] !== exp_r.smoothed_level)
        report_mismatch($sformatf("smoothed_level %0d, want %0d",
                                  tdata[18:3], exp_r.smoothed_level));
      if (tdata[23:19] !== 5'd0)
        report_mismatch($sformatf("pad bits %b not zero", tdata[23:19]));
    endtask

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;
  logic [0:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [IdxW-1:0]   cfg_index_i;
  logic [CfgW-1:0]   cfg_data_i;

  trigger_scoreboard sb = new();
  bit                no_idle;
  int unsigned       quiet_cycles;

  // Mirror of the threshold written last, used to aim levels around it.
  logic [LevelW-1:0] cur_threshold;

  level_trigger_hold_release u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Mostly back to back, some short gaps and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result sink with random back-pressure.
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        m_axis_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Observe every handshake at the clock edge and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser[0], s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(cfg_index_i, cfg_data_i);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [LevelW-1:0] level);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tuser[0] <= cmd;
    s_axis_tdata    <= level;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_THRESHOLD) cur_threshold = data;
  endtask

  task automatic write_all(input logic [AlphaW-1:0] alpha, input logic [LevelW-1:0] thr,
                           input logic [LevelW-1:0] hy, input logic [MsW-1:0] deb,
                           input logic [MsW-1:0] hld, input logic [MsW-1:0] rel);
    write_reg(REG_ALPHA, CfgW'(alpha));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HYST, hy);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_HOLD, hld);
    write_reg(REG_RELEASE, rel);
  endtask

  function automatic logic [MsW-1:0] pick_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return MsW'($urandom_range(0, 6));
    if (r < 95) return MsW'($urandom_range(7, 20));
    return MsW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [AlphaW-1:0] pick_alpha();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return AlphaW'($urandom_range(0, 2));
    if (r < 20) return AlphaW'($urandom_range(257, 511));
    if (r < 35) return AlphaMax;
    return AlphaW'($urandom_range(32, 255));
  endfunction

  // Level aimed at or above, or below, the current threshold.
  function automatic logic [LevelW-1:0] aimed_level(bit high);
    if (high) return LevelW'($urandom_range(32'(cur_threshold), 65535));
    if (cur_threshold == 0) return '0;
    return LevelW'($urandom_range(0, 32'(cur_threshold) - 1));
  endfunction

  // Mostly bursts of samples that push the average one way, then a run of ticks; else single random items.
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned k;
    bit          high;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        high = $urandom_range(0, 1);
        k = $urandom_range(1, 4);
        repeat (k) send_item(CMD_SAMPLE, aimed_level(high));
        sent += k;
        k = $urandom_range(1, 12);
        repeat (k) send_item(CMD_TICK, LevelW'($urandom_range(0, 65535)));
        sent += k;
      end else begin
        send_item(logic'($urandom_range(0, 1)), LevelW'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    s_axis_tuser    <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= REG_ALPHA;
    cfg_data_i      <= '0;
    quiet_cycles    <= 0;
    no_idle         = 1'b0;
    cur_threshold   = ThresholdReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: plain threshold crossings with no delays, including
    // levels exactly at and just under the threshold.
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'hFFFF);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_SAMPLE, 16'h0000);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_SAMPLE, 16'd32768);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_SAMPLE, 16'd32767);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_TICK, 16'h0000);
    drain();

    // Alpha below the minimum, hysteresis larger than the threshold so the
    // lowered threshold clamps at zero, short debounce, hold and release.
    write_reg(RegUnused, 16'hFFFF);
    write_all(9'd0, 16'd100, 16'hFFFF, 16'd2, 16'd1, 16'd1);
    send_item(CMD_SAMPLE, 16'hFFFF);
    repeat (4) send_item(CMD_TICK, 16'h0000);
    send_item(CMD_SAMPLE, 16'h0000);
    repeat (2) send_item(CMD_TICK, 16'h0000);
    drain();

    // Alpha above full scale and every timing register at its maximum.
    write_all(9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'hFFFF);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_SAMPLE, 16'h5A5A);
    send_item(CMD_TICK, 16'hA5A5);
    drain();

    // Random settings, some phases without any idling.
    for (int p = 0; p < RandomPhases; p++) begin
      write_all(pick_alpha(), LevelW'($urandom_range(0, 65535)),
                ($urandom_range(0, 1) != 0) ? LevelW'($urandom_range(0, 65535))
                                            : LevelW'($urandom_range(0, 4000)),
                pick_ms(), pick_ms(), pick_ms());
      no_idle = ($urandom_range(0, 3) == 0);
      run_phase(PhaseItems);
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
